[src/lpd_pkg.sv]
// shared types and constants for the length-prefixed deframer
`timescale 1ns / 1ps

package lpd_pkg;

  localparam int unsigned LEN_W       = 16;   // payload length and counter width
  localparam int unsigned HDR_CNT_W   = 2;    // counts the four header bytes
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd4096;
  localparam logic [LEN_W-1:0] LEN_SAT       = 16'hffff;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST  = 2'd3;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_MALFORMED = 2'd1,
    KIND_ABORT     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_DEAD    = 3'b100
  } phase_t;

  typedef struct packed {
    logic       cmd;      // 1 = link reset
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       payload_byte;
    logic             last;
    logic [LEN_W-1:0] frame_length;
  } res_item_t;

endpackage

[src/lpd_in_reg.sv]
// input register stage of the deframer
`timescale 1ns / 1ps

module lpd_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpd_pkg::in_item_t in_item,
  input  logic              consume,
  output logic              held_valid,
  output lpd_pkg::in_item_t held_item
);
  import lpd_pkg::*;

  assign in_ready = !held_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

[src/lpd_core.sv]
// header parser, payload counter and link state of the deframer
`timescale 1ns / 1ps

module lpd_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [lpd_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                      consume,
  input  lpd_pkg::in_item_t         item,
  output logic                      res_valid,
  output lpd_pkg::res_item_t        res
);
  import lpd_pkg::*;

  logic [LEN_W-1:0]     max_len;
  phase_t               phase, phase_next;
  logic [HDR_CNT_W-1:0] hdr_cnt, hdr_cnt_next;
  logic                 hdr_hi, hdr_hi_next;     // upper header half nonzero
  logic [LEN_W-1:0]     hdr_len, hdr_len_next;
  logic [LEN_W-1:0]     remaining, remaining_next;

  logic [LEN_W-1:0]     full_len;
  logic                 byte_nz;
  logic                 is_last;

  assign full_len = {hdr_len[LEN_W-9:0], item.rx_byte};
  assign byte_nz  = (item.rx_byte != 8'd0);
  assign is_last  = (remaining <= LEN_W'(1));

  always_comb begin
    phase_next     = phase;
    hdr_cnt_next   = hdr_cnt;
    hdr_hi_next    = hdr_hi;
    hdr_len_next   = hdr_len;
    remaining_next = remaining;
    res_valid      = 1'b0;
    res.kind         = KIND_PAYLOAD;
    res.payload_byte = 8'd0;
    res.last         = 1'b0;
    res.frame_length = hdr_len;

    if (item.cmd) begin
      // link reset: abort only if a frame was streaming
      res_valid      = (phase == PH_PAYLOAD);
      res.kind       = KIND_ABORT;
      phase_next     = PH_HEADER;
      hdr_cnt_next   = '0;
      hdr_hi_next    = 1'b0;
      hdr_len_next   = '0;
      remaining_next = '0;
    end else begin
      unique case (phase)
        PH_DEAD: begin
        end
        PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res.payload_byte = item.rx_byte;
          res.last         = is_last;
          if (is_last) begin
            phase_next     = PH_HEADER;
            hdr_cnt_next   = '0;
            hdr_hi_next    = 1'b0;
            hdr_len_next   = '0;
            remaining_next = '0;
          end else begin
            remaining_next = LEN_W'(remaining - LEN_W'(1));
          end
        end
        default: begin
          // header collection, also taken for unused phase codes
          hdr_cnt_next = HDR_CNT_W'(hdr_cnt + HDR_CNT_W'(1));
          hdr_len_next = full_len;
          if (hdr_cnt == '0) begin
            hdr_hi_next = byte_nz;
          end else if (hdr_cnt == HDR_CNT_W'(1)) begin
            hdr_hi_next = hdr_hi | byte_nz;
          end
          if (hdr_cnt == HDR_LAST) begin
            if (hdr_hi || (full_len == '0) || (full_len > max_len)) begin
              res_valid        = 1'b1;
              res.kind         = KIND_MALFORMED;
              res.frame_length = hdr_hi ? LEN_SAT : full_len;
              phase_next       = PH_DEAD;
              remaining_next   = '0;
            end else begin
              phase_next     = PH_PAYLOAD;
              remaining_next = full_len;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len   <= MAX_LEN_RESET;
      phase     <= PH_HEADER;
      hdr_cnt   <= '0;
      hdr_hi    <= 1'b0;
      hdr_len   <= '0;
      remaining <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
      if (consume) begin
        phase     <= phase_next;
        hdr_cnt   <= hdr_cnt_next;
        hdr_hi    <= hdr_hi_next;
        hdr_len   <= hdr_len_next;
        remaining <= remaining_next;
      end
    end
  end

endmodule

[src/lpd_out_reg.sv]
// result register stage of the deframer
`timescale 1ns / 1ps

module lpd_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_valid,
  input  lpd_pkg::res_item_t load_item,
  output logic               slot_free,
  output logic               out_valid,
  input  logic               out_ready,
  output lpd_pkg::res_item_t out_item
);
  import lpd_pkg::*;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && load_valid) begin
      out_item <= load_item;
    end
  end

endmodule

[src/length_prefixed_deframer.sv]
// top level of the length-prefixed stream deframer
// an accepted item is held in lpd_in_reg, and its result is registered in lpd_out_reg
// throughput: one item per cycle while the result slot is free, each stepped by lpd_core
// items that give no result (header bytes, dead-link bytes) still step through lpd_core
// reset: rst clears both stage valids and the link state, max_frame_len returns to 4096
`timescale 1ns / 1ps

module length_prefixed_deframer (
  input  logic        clk,
  input  logic        rst,
  // configuration: max_frame_len
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // received stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] cmd (1 = link reset)
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] frame_length
  output logic        m_axis_tlast,   // last payload byte of a frame
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);
  import lpd_pkg::*;

  in_item_t  s_item;
  in_item_t  held_item;
  logic      held_valid;
  logic      consume;
  logic      slot_free;
  logic      res_valid;
  res_item_t res;
  res_item_t out_item;

  assign s_item.cmd     = s_axis_tuser;
  assign s_item.rx_byte = s_axis_tdata;

  // the held item steps through the core whenever the result slot can take its outcome
  assign consume = held_valid && slot_free;

  lpd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (s_item),
    .consume    (consume),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  lpd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .consume     (consume),
    .item        (held_item),
    .res_valid   (res_valid),
    .res         (res)
  );

  // only items that produce a result fill the output slot
  lpd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (consume && res_valid),
    .load_item  (res),
    .slot_free  (slot_free),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_item   (out_item)
  );

  assign m_axis_tdata = {out_item.frame_length, out_item.payload_byte};
  assign m_axis_tlast = out_item.last;
  assign m_axis_tuser = out_item.kind;

endmodule

[dv/length_prefixed_deframer_test.sv]
// self-checking testbench for the length-prefixed deframer
`timescale 1ns / 1ps

module length_prefixed_deframer_test;
  import lpd_pkg::*;

  // run limit, far above the slowest legal run (stalls, gaps and the long hold-off)
  localparam int unsigned RUN_LIMIT_NS = 3_000_000;
  localparam int unsigned ITEMS_PER_SETTING = 200;
  localparam int unsigned SETTLE_CYCLES = 8;   // margin after the last expected result
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_LINK_RESET = 1'b1;

  // expected-result store with its own copy of the deframer state
  class lpd_scoreboard;
    logic [15:0] max_len;
    phase_t      link_phase;
    logic [2:0]  hdr_count;
    logic [31:0] hdr_value;
    logic [15:0] bytes_left;
    res_item_t   pending_results[$];
    int unsigned fail_count;

    function new();
      max_len = MAX_LEN_RESET;
      clear_link();
      fail_count = 0;
    endfunction

    function void clear_link();
      link_phase = PH_HEADER;
      hdr_count  = 3'd0;
      hdr_value  = 32'd0;
      bytes_left = 16'd0;
    endfunction

    function void queue_result(kind_t k, logic [7:0] b, logic l, logic [31:0] len);
      res_item_t r;
      r.kind = k;
      r.payload_byte = b;
      r.last = l;
      r.frame_length = (len > 32'h0000_ffff) ? LEN_SAT : len[15:0];
      pending_results.push_back(r);
    endfunction

    // one accepted item through the deframer
    function void deframe_item(logic cmd, logic [7:0] b);
      if (cmd == CMD_LINK_RESET) begin
        if (link_phase == PH_PAYLOAD) queue_result(KIND_ABORT, 8'd0, 1'b0, hdr_value);
        clear_link();
        return;
      end
      case (link_phase)
        PH_DEAD: ;
        PH_PAYLOAD: begin
          queue_result(KIND_PAYLOAD, b, bytes_left <= 16'd1, hdr_value);
          if (bytes_left <= 16'd1) clear_link();
          else bytes_left = bytes_left - 16'd1;
        end
        default: begin
          hdr_value = (hdr_count == 3'd0) ? {24'd0, b} : {hdr_value[23:0], b};
          hdr_count = hdr_count + 3'd1;
          if (hdr_count == 3'd4) begin
            hdr_count = 3'd0;
            // anything above the 16-bit counter range is also above the register
            if (hdr_value == 32'd0 || hdr_value > {16'd0, max_len}) begin
              link_phase = PH_DEAD;
              bytes_left = 16'd0;
              queue_result(KIND_MALFORMED, 8'd0, 1'b0, hdr_value);
            end else begin
              link_phase = PH_PAYLOAD;
              bytes_left = hdr_value[15:0];
            end
          end
        end
      endcase
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: kind %0d byte %02h last %b len %0d",
                   got.kind, got.payload_byte, got.last, got.frame_length);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
          got.last !== want.last || got.frame_length !== want.frame_length) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"mismatch: expected kind %0d byte %02h last %b len %0d, ",
                    "got kind %0d byte %02h last %b len %0d"},
                   want.kind, want.payload_byte, want.last, want.frame_length,
                   got.kind, got.payload_byte, got.last, got.frame_length);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        s_axis_tuser;   // [0] cmd (1 = link reset)
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] payload_byte, [23:8] frame_length
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;   // [1:0] kind

  lpd_scoreboard sb;
  int unsigned   items_sent;
  int unsigned   burst_left;
  bit            hold_off_req;

  length_prefixed_deframer DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // receiver: changes stall mode after each random-length run, and on request holds off
  // for a long stretch so the input side backs up
  initial begin
    int unsigned mode_left;
    int unsigned mode;
    int unsigned hold_left;
    int unsigned tick;
    mode_left = 0;
    mode = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: m_axis_tready <= 1'b1;                          // no stalls at all
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
          default: m_axis_tready <= (tick % 4 != 3);         // fixed rhythm
        endcase
      end
    end
  end

  // results are compared at the edge where they are taken
  always @(posedge clk) begin
    res_item_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = kind_t'(m_axis_tuser);
      got.payload_byte = m_axis_tdata[7:0];
      got.last = m_axis_tlast;
      got.frame_length = m_axis_tdata[23:8];
      sb.check_result(got);
    end
  end

  // offer one item, in bursts with random gaps between them
  task automatic send_item(logic cmd, logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    sb.deframe_item(cmd, b);
    items_sent++;
  endtask

  // 4-byte big-endian header followed by a number of random bytes
  task automatic send_frame(logic [31:0] hdr, int unsigned n_bytes);
    send_item(CMD_DATA, hdr[31:24]);
    send_item(CMD_DATA, hdr[23:16]);
    send_item(CMD_DATA, hdr[15:8]);
    send_item(CMD_DATA, hdr[7:0]);
    repeat (n_bytes) send_item(CMD_DATA, 8'($urandom_range(0, 255)));
  endtask

  // drain: header bytes give nothing back, so give the pipeline time after the last result
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(logic [15:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.max_len = value;
  endtask

  // mostly complete frames, plus cut frames, bad headers, stray resets and noise
  task automatic run_random(logic [15:0] max_len, int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned cap;
    int unsigned big_cap;
    int unsigned len;
    logic [31:0] bad_hdr;
    stop_at = items_sent + n_items;
    cap = (max_len > 16'd24) ? 32'd24 : {16'd0, max_len};
    big_cap = (max_len > 16'd300) ? 32'd300 : {16'd0, max_len};
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, big_cap) : $urandom_range(1, cap);
        if ($urandom_range(0, 7) == 0 && max_len <= 16'd300) len = {16'd0, max_len};
        send_frame(len, len);
      end else if (pick < 70) begin
        // payload cut short by a link reset
        len = $urandom_range(1, big_cap);
        send_frame(len, $urandom_range(0, len - 1));
        send_item(CMD_LINK_RESET, 8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
        case ($urandom_range(0, 2))
          0: bad_hdr = 32'd0;
          1: bad_hdr = {16'd0, max_len} + 32'd1;
          default: bad_hdr = $urandom() | (32'd1 << $urandom_range(16, 31));
        endcase
        send_frame(bad_hdr, $urandom_range(0, 4));   // trailing bytes hit the dead link
        send_item(CMD_LINK_RESET, 8'($urandom_range(0, 255)));
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 3)) send_item(CMD_DATA, 8'($urandom_range(0, 255)));
        send_item(CMD_LINK_RESET, 8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        send_item(CMD_LINK_RESET, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        send_item(CMD_LINK_RESET, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    burst_left = 0;
    hold_off_req = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 16'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, default limit of 4096
    send_frame(32'd0, 0);                         // zero length is malformed
    send_item(CMD_DATA, 8'hff);                   // dead link swallows data
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_LINK_RESET, 8'h00);             // reset while dead, silent
    send_frame(32'd1, 0);
    send_item(CMD_DATA, 8'hff);                   // single byte frame, marked last
    send_frame(32'd2, 0);
    send_item(CMD_DATA, 8'h5a);
    send_item(CMD_LINK_RESET, 8'hff);             // reset mid payload gives an abort
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_LINK_RESET, 8'h00);             // reset mid header, silent
    send_frame(32'hffff_ffff, 0);                 // huge length, saturated in the result
    send_item(CMD_LINK_RESET, 8'h00);

    // limit of zero turns every header away
    write_max_len(16'd0);
    send_frame(32'd1, 0);
    send_item(CMD_LINK_RESET, 8'h00);

    // widest limit: long hold-off on the result side while a frame keeps coming
    write_max_len(16'hffff);
    hold_off_req = 1'b1;
    send_frame(32'd150, 150);
    send_frame(32'h0001_0000, 0);                 // one past the limit
    send_item(CMD_LINK_RESET, 8'h00);
    send_frame(32'h0000_ffff, 3);                 // largest length, then cut off
    send_item(CMD_LINK_RESET, 8'h00);
    run_random(16'hffff, ITEMS_PER_SETTING);

    write_max_len(16'd1);
    run_random(16'd1, ITEMS_PER_SETTING);
    write_max_len(16'd16);
    run_random(16'd16, ITEMS_PER_SETTING);
    cfg_wr_data = 16'($urandom_range(2, 400));
    write_max_len(cfg_wr_data);
    run_random(sb.max_len, ITEMS_PER_SETTING);
    write_max_len(MAX_LEN_RESET);
    run_random(MAX_LEN_RESET, ITEMS_PER_SETTING);

    wait_drained();
    if (sb.fail_count == 0 && sb.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/lpd_pkg.sv
src/lpd_in_reg.sv
src/lpd_core.sv
src/lpd_out_reg.sv
src/length_prefixed_deframer.sv
dv/length_prefixed_deframer_test.sv
